/* rtl/tsoe_pkg.sv */
// ----------------------------------------------------------------------------
// tsoe_pkg
// Shared constants and types for the tick signal order engine.
// ----------------------------------------------------------------------------
package tsoe_pkg;

    localparam int INSTRUMENTS_DEF = 16;
    localparam int WINDOW_DEF      = 10;
    localparam int PRICE_BITS_DEF  = 24;

    localparam int INST_W = 4;
    localparam int SIG_W  = 2;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] REG_LOW   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_HIGH  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_BELOW = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ABOVE = 3'd3;
    localparam logic [ADDR_W-1:0] REG_MINS  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_SEED  = 3'd5;

    localparam logic [SIG_W-1:0] SIG_THRESH = 2'd0;
    localparam logic [SIG_W-1:0] SIG_DEV    = 2'd1;
    localparam logic [SIG_W-1:0] SIG_MOM    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic [23:0] low_threshold;
        logic [23:0] high_threshold;
        logic [6:0]  below_avg_pct;
        logic [7:0]  above_avg_pct;
        logic [3:0]  avg_min_samples;
    } cfg_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic b;
        b = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {b, s[15:1]};
    endfunction

endpackage

/* rtl/tsoe_ram.sv */
// ----------------------------------------------------------------------------
// tsoe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tsoe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/tsoe_cfg.sv */
// ----------------------------------------------------------------------------
// tsoe_cfg
// APB register file for thresholds, percentages and LFSR seed.
// ----------------------------------------------------------------------------
module tsoe_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [tsoe_pkg::ADDR_W+1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output tsoe_pkg::cfg_t        cfg,
    output logic                  seed_load,
    output logic [15:0]           seed_value
);
    import tsoe_pkg::*;

    cfg_t        cfg_reg;
    logic [15:0] seed_reg;
    logic        wr;
    logic [ADDR_W-1:0] idx;

    assign idx = paddr[ADDR_W+1:2];
    assign wr  = psel && penable && pwrite;
    assign seed_load  = wr && (idx == REG_SEED);
    assign seed_value = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold   <= 24'd10500;
            cfg_reg.high_threshold  <= 24'd19500;
            cfg_reg.below_avg_pct   <= 7'd98;
            cfg_reg.above_avg_pct   <= 8'd102;
            cfg_reg.avg_min_samples <= 4'd5;
            seed_reg                <= 16'd44257;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_LOW:   cfg_reg.low_threshold   <= pwdata[23:0];
                REG_HIGH:  cfg_reg.high_threshold  <= pwdata[23:0];
                REG_BELOW: cfg_reg.below_avg_pct   <= pwdata[6:0];
                REG_ABOVE: cfg_reg.above_avg_pct   <= pwdata[7:0];
                REG_MINS:  cfg_reg.avg_min_samples <= pwdata[3:0];
                REG_SEED:  seed_reg                <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LOW:   prdata = {8'd0, cfg_reg.low_threshold};
            REG_HIGH:  prdata = {8'd0, cfg_reg.high_threshold};
            REG_BELOW: prdata = {25'd0, cfg_reg.below_avg_pct};
            REG_ABOVE: prdata = {24'd0, cfg_reg.above_avg_pct};
            REG_MINS:  prdata = {28'd0, cfg_reg.avg_min_samples};
            REG_SEED:  prdata = {16'd0, seed_reg};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/tick_signal_order_engine.sv */
// ----------------------------------------------------------------------------
// tick_signal_order_engine
// Per-instrument price window with threshold, deviation and momentum signals.
// ----------------------------------------------------------------------------
// Sequence: an item is accepted in IDLE, READ captures the per-instrument
//   state and starts the window slot read, EVAL writes the state back and
//   registers the result; no new item is taken until IDLE, nor while out_stall holds a result.
// Reset: window counts, heads and sums are cleared through valid bits; the
//   price window memory is undefined until written; LFSR loads the seed.
// One result item per input item (order_valid = 0 when nothing fires).
module tick_signal_order_engine #(
    parameter int INSTRUMENTS = tsoe_pkg::INSTRUMENTS_DEF,
    parameter int WINDOW      = tsoe_pkg::WINDOW_DEF,
    parameter int PRICE_BITS  = tsoe_pkg::PRICE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tsoe_pkg::INST_W-1:0]   instrument,
    input  logic [PRICE_BITS-1:0]         price,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          order_valid,
    output logic                          order_is_buy,
    output logic [tsoe_pkg::INST_W-1:0]   order_instrument,
    output logic [PRICE_BITS-1:0]         order_price,
    output logic [tsoe_pkg::SIG_W-1:0]    order_signal,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsoe_pkg::ADDR_W+1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tsoe_pkg::*;

    localparam int IW   = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SUMW = PRICE_BITS + $clog2(WINDOW + 1);
    localparam int DEPTH = INSTRUMENTS * WINDOW;
    localparam int AW   = $clog2(DEPTH);
    // Meta memory word: sum, head, count
    localparam int MW   = SUMW + SW + CW;
    localparam int LHSW = PRICE_BITS + 7 + CW;
    localparam int RHSW = SUMW + 8;

    cfg_t        cfg;
    logic        seed_load;
    logic [15:0] seed_value;

    assign pready = 1'b1;

    tsoe_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .cfg        (cfg),
        .seed_load  (seed_load),
        .seed_value (seed_value)
    );

    // ------------------------------------------------------------------
    // State machine: IDLE takes an item, READ waits on the memories,
    // EVAL updates state and registers the result.
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [15:0]           lfsr_reg, lfsr_next;
    logic [INST_W-1:0]     inst_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic                  in_range_reg;
    logic [INSTRUMENTS-1:0] meta_ok_reg;

    // output register
    logic                  ov_reg;
    logic                  o_valid_reg, o_buy_reg;
    logic [INST_W-1:0]     o_inst_reg;
    logic [PRICE_BITS-1:0] o_price_reg;
    logic [SIG_W-1:0]      o_sig_reg;

    assign out_valid        = ov_reg;
    assign order_valid      = o_valid_reg;
    assign order_is_buy     = o_buy_reg;
    assign order_instrument = o_inst_reg;
    assign order_price      = o_price_reg;
    assign order_signal     = o_sig_reg;

    logic accept;
    assign in_stall = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    logic [IW-1:0] in_idx, cur_idx;
    assign in_idx  = instrument[IW-1:0];
    assign cur_idx = inst_reg[IW-1:0];

    // ------------------------------------------------------------------
    // Memories. Price window: 3 reads needed (oldest, prev1, prev2),
    // so prev1/prev2 live in the meta word alongside sum/head/count.
    // ------------------------------------------------------------------
    localparam int MXW = MW + 2 * PRICE_BITS;

    logic           meta_we;
    logic [MXW-1:0] meta_wdata, meta_rdata;
    logic           win_we;
    logic [AW-1:0]  win_waddr, win_raddr;
    logic [PRICE_BITS-1:0] win_rdata;

    tsoe_ram #(.WIDTH(MXW), .DEPTH(INSTRUMENTS)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (cur_idx),
        .wdata (meta_wdata),
        .raddr (in_idx),
        .rdata (meta_rdata)
    );

    // Head slot is read in READ, straight from the meta read data.
    logic [SW-1:0] rd_head;
    assign rd_head = meta_ok_reg[cur_idx] ? meta_rdata[CW +: SW] : '0;
    assign win_raddr = AW'(cur_idx * WINDOW) + AW'(rd_head);

    tsoe_ram #(.WIDTH(PRICE_BITS), .DEPTH(DEPTH)) u_win (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (price_reg),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // Captured meta fields
    logic [SUMW-1:0]       m_sum_reg;
    logic [SW-1:0]         m_head_reg;
    logic [CW-1:0]         m_cnt_reg;
    logic [PRICE_BITS-1:0] m_p1_reg, m_p2_reg;

    // Evaluation datapath (EVAL)
    logic [SUMW-1:0]       new_sum;
    logic [CW-1:0]         new_cnt;
    logic [SW-1:0]         new_head;
    logic                  full;
    logic [LHSW-1:0]       lhs;
    logic [RHSW-1:0]       rhs_lo, rhs_hi;
    logic                  b_th, s_th, b_dv, s_dv, b_mo;
    logic [1:0]            nb;
    logic                  ns2, any_b, any_s, buy;
    logic [7:0]            pick;
    logic [16:0]           pick_prod;
    logic [7:0]            pick_q;
    logic [7:0]            pick_rem;
    logic [1:0]            pick_mod;
    logic [SIG_W-1:0]      sig;
    logic [SIG_W-1:0]      blist [3];
    logic [PRICE_BITS-1:0] pmax;

    assign pmax = '1;
    assign full = (m_cnt_reg >= CW'(WINDOW));
    assign new_cnt = full ? CW'(WINDOW) : m_cnt_reg + CW'(1);
    assign new_sum = m_sum_reg - (full ? SUMW'(win_rdata) : '0) + SUMW'(price_reg);
    assign new_head = (m_head_reg == SW'(WINDOW - 1)) ? '0 : m_head_reg + SW'(1);

    assign win_waddr  = AW'(cur_idx * WINDOW) + AW'(m_head_reg);
    assign meta_wdata = {price_reg, m_p1_reg, new_sum, new_head, new_cnt};

    assign lhs    = LHSW'(price_reg) * LHSW'(100) * LHSW'(new_cnt);
    assign rhs_lo = RHSW'(new_sum) * RHSW'(cfg.below_avg_pct);
    assign rhs_hi = RHSW'(new_sum) * RHSW'(cfg.above_avg_pct);

    always_comb
    begin
        b_th = (price_reg < PRICE_BITS'(cfg.low_threshold));
        s_th = !b_th && (price_reg > PRICE_BITS'(cfg.high_threshold));
        b_dv = 1'b0;
        s_dv = 1'b0;
        if ((new_cnt >= CW'(cfg.avg_min_samples)) && (new_sum != '0))
        begin
            b_dv = (RHSW'(lhs) < rhs_lo);
            s_dv = !b_dv && (RHSW'(lhs) > rhs_hi);
        end
        b_mo = (new_cnt >= CW'(3)) && (m_p1_reg > m_p2_reg) && (price_reg > m_p1_reg);

        nb = 2'(b_th) + 2'(b_dv) + 2'(b_mo);
        ns2 = s_th && s_dv;
        any_b = (nb != 2'd0);
        any_s = s_th || s_dv;
        buy = (any_b && any_s) ? !lfsr_reg[0] : any_b;

        // Compact list of buy candidates in signal order
        blist[0] = b_th ? SIG_THRESH : (b_dv ? SIG_DEV : SIG_MOM);
        blist[1] = (b_th && b_dv) ? SIG_DEV : SIG_MOM;
        blist[2] = SIG_MOM;

        // pick mod 3: floor(x/3) = (x*171)>>9, exact for 8-bit x
        pick      = lfsr_reg[15:8];
        pick_prod = 17'(pick) * 17'd171;
        pick_q    = pick_prod[16:9];
        pick_rem  = pick - pick_q * 8'd3;
        priority case (nb)
            2'd3:    pick_mod = pick_rem[1:0];
            2'd2:    pick_mod = {1'b0, pick[0]};
            default: pick_mod = 2'd0;
        endcase

        if (buy)
            sig = blist[pick_mod];
        else if (ns2)
            sig = lfsr_reg[1] ? SIG_DEV : SIG_THRESH;
        else
            sig = s_th ? SIG_THRESH : SIG_DEV;
    end

    assign meta_we = (state_reg == ST_EVAL) && in_range_reg;
    assign win_we  = meta_we;

    always_comb
    begin
        state_next = state_reg;
        lfsr_next  = lfsr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                    lfsr_next  = lfsr_step(lfsr_reg);
                end
            end
            ST_READ: state_next = ST_EVAL;
            ST_EVAL: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (seed_load)
            lfsr_next = seed_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lfsr_reg    <= 16'd44257;
            meta_ok_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lfsr_reg  <= lfsr_next;
            if (meta_we)
                meta_ok_reg[cur_idx] <= 1'b1;
            if (state_reg == ST_EVAL)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inst_reg     <= instrument;
            price_reg    <= price;
            in_range_reg <= (32'(instrument) < INSTRUMENTS);
        end
        if (state_reg == ST_READ)
        begin
            if (meta_ok_reg[cur_idx])
            begin
                {m_p1_reg, m_p2_reg, m_sum_reg, m_head_reg, m_cnt_reg} <= meta_rdata;
            end
            else
            begin
                m_sum_reg  <= '0;
                m_head_reg <= '0;
                m_cnt_reg  <= '0;
                m_p1_reg   <= '0;
                m_p2_reg   <= '0;
            end
        end
        if (state_reg == ST_EVAL)
        begin
            o_valid_reg <= in_range_reg && (any_b || any_s);
            o_buy_reg   <= in_range_reg && (any_b || any_s) && buy;
            o_inst_reg  <= (in_range_reg && (any_b || any_s)) ? inst_reg : '0;
            o_sig_reg   <= (in_range_reg && (any_b || any_s)) ? sig : '0;
            if (!(in_range_reg && (any_b || any_s)))
                o_price_reg <= '0;
            else if (buy)
                o_price_reg <= (price_reg == pmax) ? pmax : price_reg + PRICE_BITS'(1);
            else
                o_price_reg <= (price_reg == '0) ? '0 : price_reg - PRICE_BITS'(1);
        end
    end

endmodule
